/* rtl/mconv_pkg.sv */
// ----------------------------------------------------------------------------
// mconv_pkg
// Shared types, codes and constants of the multichannel convolution block.
// ----------------------------------------------------------------------------
package mconv_pkg;

    // default sizes
    localparam int MAX_SIDE_DEF     = 64;
    localparam int MAX_CHANNELS_DEF = 4;
    localparam int MAX_KERNEL_DEF   = 7;
    localparam int SAMPLE_BITS_DEF  = 16;

    // internal widths, sized for the largest legal parameter values
    localparam int KD_W  = 4;   // kernel index and side, up to 15
    localparam int CH_W  = 5;   // channel index and count, up to 16
    localparam int GEO_W = 12;  // signed centre and tap position
    localparam int SUM_W = 40;

    // request operations
    typedef enum logic [1:0] {
        OP_WRITE_SAMPLE = 2'd0,
        OP_WRITE_WEIGHT = 2'd1,
        OP_COMPUTE      = 2'd2,
        OP_UNUSED       = 2'd3
    } op_t;

    // configuration register indexes
    localparam logic [2:0] CFG_IMAGE_HEIGHT  = 3'd0;
    localparam logic [2:0] CFG_IMAGE_WIDTH   = 3'd1;
    localparam logic [2:0] CFG_CHANNEL_COUNT = 3'd2;
    localparam logic [2:0] CFG_KERNEL_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_KERNEL_WIDTH  = 3'd4;
    localparam logic [2:0] CFG_STEP_SIZE     = 3'd5;
    localparam logic [2:0] CFG_EDGE_MODE     = 3'd6;

    typedef struct packed {
        logic [1:0]         op;
        logic [5:0]         row_index;
        logic [5:0]         col_index;
        logic [1:0]         chan_index;
        logic signed [15:0] sample_value;
    } in_item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] conv_sum;
        logic [5:0]              out_row;
        logic [5:0]              out_col;
        logic                    in_grid;
    } out_item_t;

    typedef struct packed {
        logic [6:0] image_height;
        logic [6:0] image_width;
        logic [2:0] channel_count;
        logic [2:0] kernel_height;
        logic [2:0] kernel_width;
        logic [3:0] step_size;
        logic       edge_mode;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic            write_img;
        logic            write_wgt;
        logic            load;
        logic            issue;
        logic [CH_W-1:0] chan;
        logic [KD_W-1:0] ki;
        logic [KD_W-1:0] kj;
        logic            out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic            in_grid;
        logic [CH_W-1:0] nc;
        logic [KD_W-1:0] kh;
        logic [KD_W-1:0] kw;
    } status_t;

endpackage

/* rtl/multichannel_2d_convolution_top.sv */
// ----------------------------------------------------------------------------
// multichannel_2d_convolution_top
// Strided multichannel 2D convolution for one output plane, zero padded or unpadded by edge mode.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_stall/in_data): each request either writes an
//   image sample, writes a kernel weight, or asks for one output position.
//   Writes give no result and leave in_stall low. A compute request gives one
//   result on the out channel (out_valid/out_stall/out_data).
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) sets image size,
//   channel count, kernel size, stride and edge mode. It is always ready; the
//   user must write it only while no compute request is in flight (not enforced).
// Sequencing:
//   a compute request inside the grid steps through check, run, drain and done,
//   one tap per cycle through the single multiply-accumulate unit and the
//   registered store reads; outside the grid it goes from check straight to
//   done. No new request is taken until the result is loaded into the output
//   register; a result waiting under out_stall holds and the next request may
//   already run, finishing only when the output register frees up.
// Reset: clears control and config registers to their defaults; the stores
//   are not cleared and must be written before they are read.
// ----------------------------------------------------------------------------
module multichannel_2d_convolution_top #(
    parameter int MAX_SIDE     = mconv_pkg::MAX_SIDE_DEF,
    parameter int MAX_CHANNELS = mconv_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_KERNEL   = mconv_pkg::MAX_KERNEL_DEF,
    parameter int SAMPLE_BITS  = mconv_pkg::SAMPLE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  mconv_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output mconv_pkg::out_item_t out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [6:0]           cfg_data
);
    mconv_pkg::cfg_t    cfg_reg;
    mconv_pkg::cmd_t    cmd;
    mconv_pkg::status_t status;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_height  <= 7'd28;
            cfg_reg.image_width   <= 7'd28;
            cfg_reg.channel_count <= 3'd1;
            cfg_reg.kernel_height <= 3'd3;
            cfg_reg.kernel_width  <= 3'd3;
            cfg_reg.step_size     <= 4'd1;
            cfg_reg.edge_mode     <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mconv_pkg::CFG_IMAGE_HEIGHT:  cfg_reg.image_height  <= cfg_data;
                mconv_pkg::CFG_IMAGE_WIDTH:   cfg_reg.image_width   <= cfg_data;
                mconv_pkg::CFG_CHANNEL_COUNT: cfg_reg.channel_count <= cfg_data[2:0];
                mconv_pkg::CFG_KERNEL_HEIGHT: cfg_reg.kernel_height <= cfg_data[2:0];
                mconv_pkg::CFG_KERNEL_WIDTH:  cfg_reg.kernel_width  <= cfg_data[2:0];
                mconv_pkg::CFG_STEP_SIZE:     cfg_reg.step_size     <= cfg_data[3:0];
                mconv_pkg::CFG_EDGE_MODE:     cfg_reg.edge_mode     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    mconv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_op     (in_data.op),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    mconv_dp #(
        .MAX_SIDE     (MAX_SIDE),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_KERNEL   (MAX_KERNEL),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

`ifndef SYNTHESIS
    // a compute request holds off the next request
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.op == mconv_pkg::OP_COMPUTE) |=> in_stall)
        else $error("compute request did not block the input");

    // position outside the grid gives a zero sum
    a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.in_grid) |-> (out_data.conv_sum == '0))
        else $error("nonzero sum outside the grid");

    // result register loads only when free
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("result overwritten while stalled");
`endif

endmodule

/* rtl/mconv_dp.sv */
// ----------------------------------------------------------------------------
// mconv_dp
// Sample and weight stores, request geometry, tap addressing and the
// pipelined multiply-accumulate with a saturating 40-bit sum.
// ----------------------------------------------------------------------------
module mconv_dp #(
    parameter int MAX_SIDE     = mconv_pkg::MAX_SIDE_DEF,
    parameter int MAX_CHANNELS = mconv_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_KERNEL   = mconv_pkg::MAX_KERNEL_DEF,
    parameter int SAMPLE_BITS  = mconv_pkg::SAMPLE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mconv_pkg::cfg_t      cfg,
    input  mconv_pkg::in_item_t  in_data,
    input  mconv_pkg::cmd_t      cmd,
    output mconv_pkg::status_t   status,
    output mconv_pkg::out_item_t out_data
);
    localparam int IMG_DEPTH = MAX_CHANNELS * MAX_SIDE * MAX_SIDE;
    localparam int WGT_DEPTH = MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
    localparam int IAW       = $clog2(IMG_DEPTH);
    localparam int WAW       = $clog2(WGT_DEPTH);
    localparam int PW        = 2 * SAMPLE_BITS;
    localparam int ACCW      = ((PW > mconv_pkg::SUM_W) ? PW : mconv_pkg::SUM_W) + 2;
    localparam int GW        = mconv_pkg::GEO_W;
    localparam int SW        = mconv_pkg::SUM_W;
    localparam int CH_W_LOC  = mconv_pkg::CH_W;
    localparam logic [31:0] MS = 32'(MAX_SIDE);
    localparam logic [31:0] MK = 32'(MAX_KERNEL);
    localparam logic signed [ACCW-1:0] SMAX = {{(ACCW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [ACCW-1:0] SMIN = {{(ACCW-SW+1){1'b1}}, {(SW-1){1'b0}}};

    logic [SAMPLE_BITS-1:0] image_mem [IMG_DEPTH];
    logic [SAMPLE_BITS-1:0] weight_mem [WGT_DEPTH];

    // clamped configuration
    logic signed [GW-1:0] h, w, kh, kw, st, xs, ys, xe, ye;
    logic [mconv_pkg::CH_W-1:0] nc;

    always_comb
    begin
        h  = (cfg.image_height == 7'd0) ? GW'(1) :
             (32'(cfg.image_height) > MS) ? GW'(MAX_SIDE) : GW'(cfg.image_height);
        w  = (cfg.image_width == 7'd0) ? GW'(1) :
             (32'(cfg.image_width) > MS) ? GW'(MAX_SIDE) : GW'(cfg.image_width);
        kh = (cfg.kernel_height == 3'd0) ? GW'(1) :
             (32'(cfg.kernel_height) > MK) ? GW'(MAX_KERNEL) : GW'(cfg.kernel_height);
        kw = (cfg.kernel_width == 3'd0) ? GW'(1) :
             (32'(cfg.kernel_width) > MK) ? GW'(MAX_KERNEL) : GW'(cfg.kernel_width);
        nc = (cfg.channel_count == 3'd0) ? CH_W_LOC'(1) :
             (32'(cfg.channel_count) > 32'(MAX_CHANNELS)) ? CH_W_LOC'(MAX_CHANNELS) :
             CH_W_LOC'(cfg.channel_count);
        st = (cfg.step_size == 4'd0) ? GW'(1) : GW'(cfg.step_size);
        xs = cfg.edge_mode ? GW'(0) : (kh >>> 1);
        ys = cfg.edge_mode ? GW'(0) : (kw >>> 1);
        xe = cfg.edge_mode ? h : h - (kh >>> 1);
        ye = cfg.edge_mode ? w : w - (kw >>> 1);
    end

    // request geometry
    logic signed [GW-1:0] x_reg, y_reg;
    logic [5:0]           row_reg, col_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            row_reg <= in_data.row_index;
            col_reg <= in_data.col_index;
            x_reg   <= xs + GW'(in_data.row_index) * st;
            y_reg   <= ys + GW'(in_data.col_index) * st;
        end
    end

    assign status.in_grid = (x_reg < xe) && (y_reg < ye);
    assign status.nc      = nc;
    assign status.kh      = kh[mconv_pkg::KD_W-1:0];
    assign status.kw      = kw[mconv_pkg::KD_W-1:0];

    // tap position and addresses
    logic signed [GW-1:0] px, py;
    logic                 tap_ok;
    logic [31:0]          img_addr_w, wgt_addr_w, wr_img_w, wr_wgt_w;
    logic signed [31:0]   val32;
    logic                 img_wr_ok, wgt_wr_ok;

    always_comb
    begin
        px = x_reg + GW'(cmd.ki) - (kh >>> 1);
        py = y_reg + GW'(cmd.kj) - (kw >>> 1);
        tap_ok = (px >= 0) && (px < h) && (py >= 0) && (py < w);
        img_addr_w = (32'(cmd.chan) * MS + 32'(px[GW-2:0])) * MS + 32'(py[GW-2:0]);
        wgt_addr_w = (32'(cmd.chan) * MK + 32'(cmd.ki)) * MK + 32'(cmd.kj);
        wr_img_w = (32'(in_data.chan_index) * MS + 32'(in_data.row_index)) * MS
                   + 32'(in_data.col_index);
        wr_wgt_w = (32'(in_data.chan_index) * MK + 32'(in_data.row_index)) * MK
                   + 32'(in_data.col_index);
        val32 = 32'(in_data.sample_value);
        img_wr_ok = (32'(in_data.row_index) < MS) && (32'(in_data.col_index) < MS)
                    && (32'(in_data.chan_index) < 32'(MAX_CHANNELS));
        wgt_wr_ok = (32'(in_data.row_index) < MK) && (32'(in_data.col_index) < MK)
                    && (32'(in_data.chan_index) < 32'(MAX_CHANNELS));
    end

    // sample store
    logic [SAMPLE_BITS-1:0] img_rd_reg, wgt_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.write_img && img_wr_ok)
            image_mem[wr_img_w[IAW-1:0]] <= val32[SAMPLE_BITS-1:0];
        img_rd_reg <= image_mem[img_addr_w[IAW-1:0]];
    end

    // weight store
    always_ff @(posedge clk)
    begin
        if (cmd.write_wgt && wgt_wr_ok)
            weight_mem[wr_wgt_w[WAW-1:0]] <= val32[SAMPLE_BITS-1:0];
        wgt_rd_reg <= weight_mem[wgt_addr_w[WAW-1:0]];
    end

    // multiply and accumulate pipeline
    logic                 rd_valid_reg, prod_valid_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [SW-1:0] acc_reg;
    logic signed [ACCW-1:0] sum_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= cmd.issue && tap_ok;
            prod_valid_reg <= rd_valid_reg;
        end
    end

    always_comb
    begin
        sum_wide = ACCW'(acc_reg) + ACCW'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(img_rd_reg) * $signed(wgt_rd_reg);
        if (cmd.load)
            acc_reg <= '0;
        else if (prod_valid_reg)
        begin
            if (sum_wide > SMAX)
                acc_reg <= SMAX[SW-1:0];
            else if (sum_wide < SMIN)
                acc_reg <= SMIN[SW-1:0];
            else
                acc_reg <= sum_wide[SW-1:0];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data.conv_sum <= status.in_grid ? acc_reg : '0;
            out_data.out_row  <= row_reg;
            out_data.out_col  <= col_reg;
            out_data.in_grid  <= status.in_grid;
        end
    end

endmodule

/* rtl/mconv_ctrl.sv */
// ----------------------------------------------------------------------------
// mconv_ctrl
// Request sequencer: accepts requests, walks channels and kernel taps,
// drains the multiply pipeline and hands the result to the output register.
// ----------------------------------------------------------------------------
module mconv_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          in_op,
    output logic                out_valid,
    input  logic                out_stall,
    input  mconv_pkg::status_t  status,
    output mconv_pkg::cmd_t     cmd
);
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    localparam int CW = mconv_pkg::CH_W;
    localparam int KW = mconv_pkg::KD_W;

    state_t        state_reg, state_next;
    logic [CW-1:0] c_reg, c_next;
    logic [KW-1:0] i_reg, i_next, j_reg, j_next;
    logic          drain_reg, drain_next;
    logic          out_valid_reg, out_valid_next;
    logic          accept, last_tap, out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign last_tap  = (j_reg == status.kw - KW'(1)) && (i_reg == status.kh - KW'(1))
                       && (c_reg == status.nc - CW'(1));

    // commands
    always_comb
    begin
        cmd.write_img = accept && (in_op == mconv_pkg::OP_WRITE_SAMPLE);
        cmd.write_wgt = accept && (in_op == mconv_pkg::OP_WRITE_WEIGHT);
        cmd.load      = accept && (in_op == mconv_pkg::OP_COMPUTE);
        cmd.issue     = (state_reg == ST_RUN);
        cmd.chan      = c_reg;
        cmd.ki        = i_reg;
        cmd.kj        = j_reg;
        cmd.out_load  = (state_reg == ST_DONE) && out_free;
    end

    // next state
    always_comb
    begin
        state_next     = state_reg;
        c_next         = c_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        drain_next     = drain_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                c_next = '0;
                i_next = '0;
                j_next = '0;
                state_next = status.in_grid ? ST_RUN : ST_DONE;
            end
            ST_RUN:
            begin
                if (last_tap)
                begin
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end
                else if (j_reg == status.kw - KW'(1))
                begin
                    j_next = '0;
                    if (i_reg == status.kh - KW'(1))
                    begin
                        i_next = '0;
                        c_next = c_reg + CW'(1);
                    end
                    else
                        i_next = i_reg + KW'(1);
                end
                else
                    j_next = j_reg + KW'(1);
            end
            ST_DRAIN:
            begin
                drain_next = 1'b1;
                if (drain_reg)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            c_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            drain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            c_reg         <= c_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
